// ----- hdl/bytecode_token_decoder_macros.svh -----
// Assertion helpers for the bytecode token decoder.
`ifndef BYTECODE_TOKEN_DECODER_MACROS_SVH
`define BYTECODE_TOKEN_DECODER_MACROS_SVH

`ifndef SYNTH
`define BTD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("btd assertion failed");
`define BTD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("btd assertion failed");
`else
`define BTD_ASSERT_SAME(lbl, ante, cons)
`define BTD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/btd_pkg.sv -----
`default_nettype none
package btd_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] LEAD_SMALL_LIMIT = 8'd128;
	localparam logic [7:0] LEAD_ARG_BASE    = 8'h90;
	localparam logic [7:0] LEAD_HIGH_BASE   = 8'ha0;
	localparam logic [7:0] INDEX_MASK       = 8'h0f;
	localparam logic [7:0] LEAD_TRUE        = 8'hc1;
	localparam logic [7:0] LEAD_FALSE       = 8'hc2;
	localparam logic [7:0] LEAD_ONE         = 8'hc3;
	localparam logic [7:0] LEAD_TWO         = 8'hc5;
	localparam logic [7:0] LEAD_FOUR        = 8'hc7;
	localparam logic [7:0] LEAD_EIGHT       = 8'hc9;

	localparam logic OP_UINT    = 1'b0;
	localparam logic OP_OPERAND = 1'b1;

	typedef enum logic [2:0] {
		KIND_IMM   = 3'd0,
		KIND_REG   = 3'd1,
		KIND_ARG   = 3'd2,
		KIND_TRUE  = 3'd3,
		KIND_FALSE = 3'd4,
		KIND_BAD   = 3'd5
	} kind_t;

	// what the back end does with a queued byte
	typedef enum logic [1:0] {
		ACT_EMIT = 2'd0,
		ACT_ACC  = 2'd1,
		ACT_LAST = 2'd2
	} act_t;

	typedef struct packed {
		act_t       act;
		kind_t      kind;
		logic [7:0] data;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

// ----- hdl/btd_front.sv -----
`default_nettype none
module btd_front
	import btd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic [0:0] s_tuser,
	input  wire q_stat_t    q_stat,
	output logic            push,
	output entry_t          push_entry
);

	logic [3:0] remaining_q;
	logic [3:0] remaining_d;
	logic       has_entry;
	logic       accept;

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && has_entry;

	always_comb begin
		remaining_d = remaining_q;
		has_entry   = 1'b1;
		push_entry  = '{act: ACT_EMIT, kind: KIND_BAD, data: 8'd0};
		if (remaining_q != 4'd0) begin
			remaining_d     = remaining_q - 4'd1;
			push_entry.act  = (remaining_q == 4'd1) ? ACT_LAST : ACT_ACC;
			push_entry.kind = KIND_IMM;
			push_entry.data = s_tdata;
		end else if (s_tdata < LEAD_SMALL_LIMIT) begin
			push_entry.kind = KIND_IMM;
			push_entry.data = s_tdata;
		end else if (s_tuser[0] == OP_UINT) begin
			unique case (s_tdata)
				LEAD_ONE: begin
					remaining_d = 4'd1;
					has_entry   = 1'b0;
				end
				LEAD_TWO: begin
					remaining_d = 4'd2;
					has_entry   = 1'b0;
				end
				LEAD_FOUR: begin
					remaining_d = 4'd4;
					has_entry   = 1'b0;
				end
				LEAD_EIGHT: begin
					remaining_d = 4'd8;
					has_entry   = 1'b0;
				end
				default: push_entry.kind = KIND_BAD;
			endcase
		end else if (s_tdata < LEAD_ARG_BASE) begin
			push_entry.kind = KIND_REG;
			push_entry.data = s_tdata & INDEX_MASK;
		end else if (s_tdata < LEAD_HIGH_BASE) begin
			push_entry.kind = KIND_ARG;
			push_entry.data = s_tdata & INDEX_MASK;
		end else begin
			unique case (s_tdata)
				LEAD_TRUE:  push_entry.kind = KIND_TRUE;
				LEAD_FALSE: push_entry.kind = KIND_FALSE;
				LEAD_ONE: begin
					remaining_d = 4'd1;
					has_entry   = 1'b0;
				end
				LEAD_TWO: begin
					remaining_d = 4'd2;
					has_entry   = 1'b0;
				end
				default: push_entry.kind = KIND_BAD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= 4'd0;
		end else if (accept) begin
			remaining_q <= remaining_d;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/btd_queue.sv -----
`default_nettype none
module btd_queue
	import btd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_entry,
	input  wire logic   pop,
	output entry_t      head,
	output q_stat_t     q_stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	entry_t          slots_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign q_stat.full  = (count_q == FULL_COUNT);
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/btd_back.sv -----
`default_nettype none
module btd_back
	import btd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire entry_t      head,
	input  wire q_stat_t     q_stat,
	output logic             pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,
	output logic [2:0]       m_tuser
);

	logic [7:0][7:0] acc_q;
	logic [2:0]      pos_q;
	logic [7:0][7:0] merged;
	logic            out_free;
	logic            emit;
	logic            m_tvalid_q;
	logic [63:0]     value_q;
	kind_t           kind_q;

	assign out_free = !m_tvalid_q || m_tready;
	assign pop      = !q_stat.empty && ((head.act == ACT_ACC) || out_free);
	assign emit     = pop && (head.act != ACT_ACC);

	// final value: gathered lanes with the closing byte in its lane
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			merged[i] = (pos_q == 3'(i)) ? head.data : acc_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			pos_q      <= 3'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				unique case (head.act)
					ACT_ACC: begin
						acc_q[pos_q] <= head.data;
						pos_q        <= pos_q + 3'd1;
					end
					ACT_LAST: begin
						acc_q <= '0;
						pos_q <= 3'd0;
					end
					ACT_EMIT: ;
					default: ;
				endcase
			end
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= head.kind;
			value_q <= (head.act == ACT_LAST) ? 64'(merged) : {56'd0, head.data};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = value_q;
	assign m_tuser  = kind_q;

endmodule
`default_nettype wire

// ----- hdl/bytecode_token_decoder.sv -----
// channel  dir  tdata                 tuser
// s_*      in   [7:0] data_byte       [0] operation
// m_*      out  [63:0] token_value    [2:0] token_kind
//
// One byte a cycle in, one result a cycle out at most; the front end
// classifies each byte as it is taken and the back end gathers value bytes.
// A closing byte passes through the queue and then the output register on its way to m_tvalid.
// s_tready falls only when the byte queue is full; m_tready stalls the back end alone.
// arst_n clears the byte counters, the queue and the output valid.
`default_nettype none
`include "bytecode_token_decoder_macros.svh"
module bytecode_token_decoder
	import btd_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic [0:0]  s_tuser,   // [0] operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // [63:0] token_value
	output logic [2:0]       m_tuser    // [2:0] token_kind
);

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	entry_t  push_entry;
	entry_t  head;

	btd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	btd_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	btd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	`BTD_ASSERT_SAME(a_full_blocks_input, q_stat.full, !s_tready)
	`BTD_ASSERT_SAME(a_no_pop_when_empty, q_stat.empty, !pop)
	`BTD_ASSERT_NEXT(a_result_after_emit, pop && (head.act != ACT_ACC), m_tvalid)

endmodule
`default_nettype wire
